### rtl/i2d_pkg.sv
// Package for the decimal ASCII converter: payload types, constants and the BCD step.
package i2d_pkg;

  // Longest text: twenty digits of an unsigned 64-bit value, or a minus and nineteen digits.
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS + 1);
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;

  // Double dabble consumes two magnitude bits per cycle.
  localparam int unsigned STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEPS_WIDE_LAST   = step_t'(31);
  localparam step_t STEPS_NARROW_LAST = step_t'(15);

  localparam logic [30:0] NEED_32 = 31'd11;
  localparam logic [30:0] NEED_64 = 31'd21;
  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  // Bit positions inside the mode code.
  localparam int unsigned MODE_SIGNED_BIT = 0;
  localparam int unsigned MODE_WIDE_BIT   = 1;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] value;
    logic [30:0] space_left;
    logic [30:0] prior_length;
  } item_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        last_char;
    logic        accepted;
    logic [30:0] space_after;
    logic [30:0] length_after;
  } result_t;

  // Classified request handed from the front end to the converter.
  typedef struct packed {
    logic        ok;
    logic        neg;
    logic        wide;
    logic [63:0] mag;
    logic [30:0] space;
    logic [30:0] prior;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_COUNT,
    BK_EMIT
  } back_state_e;

  // One double dabble step: correct every digit of five or more, then shift in one bit.
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

endpackage

### rtl/i2d_front.sv
// Front end: checks the free space and forms sign and magnitude of the operand.
module i2d_front (
  input  logic          start,
  input  i2d_pkg::item_t item_i,
  input  logic          full_i,
  output logic          busy,
  output logic          push_o,
  output i2d_pkg::job_t job_o
);
  import i2d_pkg::*;

  logic        wide;
  logic        is_signed;
  logic        neg;
  logic [63:0] ext;

  assign wide      = item_i.mode[MODE_WIDE_BIT];
  assign is_signed = item_i.mode[MODE_SIGNED_BIT];
  assign neg       = is_signed & (wide ? item_i.value[63] : item_i.value[31]);

  // Narrow operands are sign or zero extended to 64 bits before negation.
  always_comb begin
    if (wide) begin
      ext = item_i.value;
    end else if (is_signed) begin
      ext = {{32{item_i.value[31]}}, item_i.value[31:0]};
    end else begin
      ext = {32'h0, item_i.value[31:0]};
    end
  end

  assign busy   = full_i;
  assign push_o = start & ~full_i;

  always_comb begin
    job_o.ok    = item_i.space_left >= (wide ? NEED_64 : NEED_32);
    job_o.neg   = neg;
    job_o.wide  = wide;
    job_o.mag   = neg ? (~ext + 64'd1) : ext;
    job_o.space = item_i.space_left;
    job_o.prior = item_i.prior_length;
  end

endmodule

### rtl/i2d_queue.sv
// Short queue of classified requests between the front end and the converter.
module i2d_queue #(
  parameter int unsigned DEPTH = i2d_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  i2d_pkg::job_t data_i,
  input  logic          pop_i,
  output i2d_pkg::job_t data_o,
  output logic          empty_o,
  output logic          full_o
);
  import i2d_pkg::*;

  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  job_t               entry_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [COUNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == COUNT_W'(DEPTH));
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + COUNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/i2d_back.sv
// Converter: double dabble to BCD, digit count, then one character per cycle.
module i2d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  i2d_pkg::job_t    job_i,
  output logic             pop_o,
  output logic             strobe_o,
  output i2d_pkg::result_t result_o
);
  import i2d_pkg::*;

  back_state_e          state_q, state_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic [63:0]          sh_q, sh_d;
  step_t                step_q, step_d;
  logic                 neg_q, neg_d;
  logic [30:0]          space_q, space_d;
  logic [30:0]          prior_q, prior_d;
  logic [30:0]          sp_q, sp_d;
  logic [30:0]          len_q, len_d;
  logic [DIG_IDX_W-1:0] dig_q, dig_d;
  logic                 minus_q, minus_d;
  logic                 strobe_q, strobe_d;
  result_t              res_q, res_d;

  logic [DIG_IDX_W-1:0] top_idx;
  logic [CNT_W-1:0]     n_chars;
  logic [31:0]          len_sum;
  logic [3:0]           digit;

  // Highest nonzero digit; an all-zero value still prints one digit.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        top_idx = DIG_IDX_W'(i);
      end
    end
  end

  assign n_chars = CNT_W'(top_idx) + CNT_W'(1) + CNT_W'(neg_q);
  assign len_sum = {1'b0, prior_q} + 32'(n_chars);
  assign digit   = bcd_q[4*dig_q +: 4];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i && job_i.ok) begin
          state_d = BK_CONV;
        end
      end
      BK_CONV: begin
        if (step_q == '0) begin
          state_d = BK_COUNT;
        end
      end
      BK_COUNT: begin
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (!minus_q && dig_q == '0) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    strobe_d = 1'b0;
    res_d    = res_q;
    bcd_d    = bcd_q;
    sh_d     = sh_q;
    step_d   = step_q;
    neg_d    = neg_q;
    space_d  = space_q;
    prior_d  = prior_q;
    sp_d     = sp_q;
    len_d    = len_q;
    dig_d    = dig_q;
    minus_d  = minus_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          neg_d   = job_i.neg;
          space_d = job_i.space;
          prior_d = job_i.prior;
          bcd_d   = '0;
          sh_d    = job_i.wide ? job_i.mag : {job_i.mag[31:0], 32'h0};
          step_d  = job_i.wide ? STEPS_WIDE_LAST : STEPS_NARROW_LAST;
          if (!job_i.ok) begin
            strobe_d           = 1'b1;
            res_d.char_code    = CHAR_NONE;
            res_d.last_char    = 1'b1;
            res_d.accepted     = 1'b0;
            res_d.space_after  = job_i.space;
            res_d.length_after = job_i.prior;
          end
        end
      end
      BK_CONV: begin
        bcd_d  = dd_step(dd_step(bcd_q, sh_q[63]), sh_q[62]);
        sh_d   = {sh_q[61:0], 2'b00};
        step_d = step_q - step_t'(1);
      end
      BK_COUNT: begin
        minus_d = neg_q;
        dig_d   = top_idx;
        sp_d    = space_q - 31'(n_chars);
        len_d   = len_sum[31] ? LEN_MAX : len_sum[30:0];
      end
      BK_EMIT: begin
        strobe_d           = 1'b1;
        res_d.accepted     = 1'b1;
        res_d.space_after  = sp_q;
        res_d.length_after = len_q;
        if (minus_q) begin
          res_d.char_code = CHAR_MINUS;
          res_d.last_char = 1'b0;
          minus_d         = 1'b0;
        end else begin
          res_d.char_code = CHAR_ZERO + {4'h0, digit};
          res_d.last_char = (dig_q == '0);
          dig_d           = dig_q - DIG_IDX_W'(1);
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    bcd_q   <= bcd_d;
    sh_q    <= sh_d;
    step_q  <= step_d;
    neg_q   <= neg_d;
    space_q <= space_d;
    prior_q <= prior_d;
    sp_q    <= sp_d;
    len_q   <= len_d;
    dig_q   <= dig_d;
    minus_q <= minus_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = res_q;

  a_conv_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CONV && step_q != '0) |=>
      (state_q == BK_CONV && step_q == step_t'($past(step_q) - step_t'(1))))
    else $error("conversion step count did not advance by one");

  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !res_q.accepted) |-> (res_q.last_char && res_q.char_code == CHAR_NONE))
    else $error("refused request must give a single empty final result");

  a_emit_strobes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EMIT) |=> (strobe_q && res_q.accepted))
    else $error("character cycle did not produce an accepted result");

  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && res_q.last_char) |-> (state_q == BK_IDLE))
    else $error("converter still busy after the final character");

endmodule

### rtl/integer_to_decimal_ascii.sv
// Top level of the integer to decimal ASCII converter.
//
// Usage: drive a request on req_i and raise start. The request transfers at a
// rising edge where start is high and busy is low. Each request carries a mode
// (32 or 64 bits, signed or unsigned), the value, the free space and the
// running text length. Results leave on res_o, one character per transfer,
// each valid for exactly one cycle while strobe_o is high; the receiver cannot
// stall them, so it must take every strobe. The last character of a request
// has last_char set. A request whose free space is below 11 bytes (32-bit
// modes) or 21 bytes (64-bit modes) gives one refused result instead.
// A front end classifies each request into a two-entry queue; the converter
// then pops it, runs double dabble at two bits per cycle, counts the digits
// and emits the characters of the text, the minus sign first. An accepted
// request holds the converter until its last character has been emitted; a
// refused one is answered when it is popped and leaves the converter idle.
// busy rises only while the queue is full. Reset clears the queue and the
// converter state; no result is pending afterwards.
module integer_to_decimal_ascii #(
  parameter int unsigned QUEUE_DEPTH = i2d_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  i2d_pkg::item_t   req_i,
  output logic             strobe_o,
  output i2d_pkg::result_t res_o
);
  import i2d_pkg::*;

  // Front end to queue.
  logic push;
  logic full;
  job_t job_in;

  // Queue to converter.
  logic pop;
  logic empty;
  job_t job_out;

  i2d_front u_front (
    .start  (start),
    .item_i (req_i),
    .full_i (full),
    .busy   (busy),
    .push_o (push),
    .job_o  (job_in)
  );

  // The queue lets the front end keep taking requests while a long
  // conversion is still emitting characters.
  i2d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty),
    .full_o  (full)
  );

  // Results are registered inside the converter, so strobe_o and res_o come
  // straight from flip-flops.
  i2d_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .job_i    (job_out),
    .pop_o    (pop),
    .strobe_o (strobe_o),
    .result_o (res_o)
  );

endmodule

### tb/tb_top.sv
// Testbench for the integer to decimal ASCII converter, with a built-in predictor.
`timescale 1ns / 1ps

module tb_top;
  import i2d_pkg::*;

  // Mode codes as the block reads them: bit 0 selects signed, bit 1 selects 64 bits.
  typedef enum logic [1:0] {
    MODE_U32,
    MODE_S32,
    MODE_U64,
    MODE_S64
  } conv_mode_e;

  // One row of the directed table. A typed row carries its expected text and
  // totals; an empty text on a typed row means a refused request. Other rows
  // go through the predictor.
  typedef struct {
    item_t       req;
    bit          typed;
    string       text;
    logic [30:0] space_after;
    logic [30:0] length_after;
  } stim_row_t;

  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  // Longest job: a 64-bit conversion plus 20 characters, with some margin.
  localparam int unsigned SETTLE_CYCLES = 80;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   req_i;
  logic    strobe_o;
  result_t res_o;

  // Characters still owed by the block, oldest first.
  result_t     pending_chars[$];
  stim_row_t   directed_rows[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  integer_to_decimal_ascii dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .strobe_o(strobe_o),
    .res_o   (res_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Works out the text of one accepted request and queues one expected
  // character per result. A request with too little free space yields a
  // single refused result that echoes the space and the running length.
  function automatic void queue_decimal_text(input item_t req);
    logic [63:0] raw;
    logic [63:0] mag;
    logic [30:0] need;
    logic [31:0] total;
    logic [7:0]  text[$];
    bit          wide;
    bit          negative;
    result_t     r;
    wide = req.mode[MODE_WIDE_BIT];
    need = wide ? NEED_64 : NEED_32;
    if (req.space_left < need) begin
      r.char_code    = CHAR_NONE;
      r.last_char    = 1'b1;
      r.accepted     = 1'b0;
      r.space_after  = req.space_left;
      r.length_after = req.prior_length;
      pending_chars.push_back(r);
      return;
    end
    // Narrow modes ignore the upper word entirely.
    raw = wide ? req.value : {32'd0, req.value[31:0]};
    negative = req.mode[MODE_SIGNED_BIT] && (wide ? raw[63] : raw[31]);
    if (negative && !wide) raw[63:32] = '1;
    // Negating in unsigned arithmetic keeps the most negative value exact.
    mag = negative ? -raw : raw;
    do begin
      text.push_front(CHAR_ZERO + 8'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    if (negative) text.push_front(CHAR_MINUS);
    total = {1'b0, req.prior_length} + 32'(text.size());
    r.accepted     = 1'b1;
    r.space_after  = req.space_left - 31'(text.size());
    r.length_after = (total > {1'b0, LEN_MAX}) ? LEN_MAX : total[30:0];
    foreach (text[i]) begin
      r.char_code = text[i];
      r.last_char = (i == text.size() - 1);
      pending_chars.push_back(r);
    end
  endfunction

  // Queues the results of a typed row straight from its text.
  function automatic void queue_typed_text(input stim_row_t row);
    result_t r;
    r.space_after  = row.space_after;
    r.length_after = row.length_after;
    if (row.text.len() == 0) begin
      r.char_code = CHAR_NONE;
      r.last_char = 1'b1;
      r.accepted  = 1'b0;
      pending_chars.push_back(r);
      return;
    end
    r.accepted = 1'b1;
    for (int i = 0; i < row.text.len(); i++) begin
      r.char_code = row.text[i];
      r.last_char = (i == row.text.len() - 1);
      pending_chars.push_back(r);
    end
  endfunction

  task automatic add_row(input conv_mode_e mode, input logic [63:0] value,
                         input logic [30:0] space, input logic [30:0] prior,
                         input bit typed, input string text,
                         input logic [30:0] space_after, input logic [30:0] length_after);
    stim_row_t row;
    row.req.mode         = mode;
    row.req.value        = value;
    row.req.space_left   = space;
    row.req.prior_length = prior;
    row.typed            = typed;
    row.text             = text;
    row.space_after      = space_after;
    row.length_after     = length_after;
    directed_rows.push_back(row);
  endtask

  // Presents one request from a falling edge and holds it until a rising edge
  // with busy low takes the transfer. Expectations are queued at that edge.
  // Returns at the following falling edge, so the caller may present the next
  // request at once with start still high.
  task automatic send_row(input stim_row_t row);
    start <= 1'b1;
    req_i <= row.req;
    do @(posedge clk_i); while (busy);
    if (row.typed) queue_typed_text(row);
    else queue_decimal_text(row.req);
    @(negedge clk_i);
  endtask

  // Lowers start for a while; the request bus carries noise meanwhile.
  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    req_i <= item_t'({$urandom, $urandom, $urandom, $urandom});
    repeat (n) @(negedge clk_i);
  endtask

  // Holds off the sender until every owed character has arrived.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [63:0] p;
    case ($urandom_range(0, 7))
      0: v = {$urandom, $urandom} >> $urandom_range(1, 63);
      1: v = 64'($urandom_range(0, 1000));
      2: begin
        // Powers of ten and their neighbors move the digit count by one.
        p = 64'd1;
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        case ($urandom_range(0, 2))
          0: v = p - 64'd1;
          1: v = p;
          default: v = p + 64'd1;
        endcase
      end
      3: v = -({$urandom, $urandom} >> $urandom_range(1, 63));
      4: begin
        case ($urandom_range(0, 7))
          0: v = 64'd0;
          1: v = 64'hFFFF_FFFF_FFFF_FFFF;
          2: v = 64'h8000_0000_0000_0000;
          3: v = 64'h7FFF_FFFF_FFFF_FFFF;
          4: v = {$urandom, 32'h8000_0000};
          5: v = {$urandom, 32'h7FFF_FFFF};
          6: v = {$urandom, 32'hFFFF_FFFF};
          default: v = {$urandom, 32'd0};
        endcase
      end
      // Narrow sizes under random junk in the upper word.
      5: v = {$urandom, $urandom >> $urandom_range(0, 31)};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t   row;
    logic [30:0] need;
    logic [30:0] r31;
    row.typed     = 1'b0;
    row.req.mode  = 2'($urandom_range(0, 3));
    row.req.value = random_value();
    need = row.req.mode[MODE_WIDE_BIT] ? NEED_64 : NEED_32;
    r31  = 31'($urandom);
    // Mostly enough space, with refusals and the exact bounds mixed in.
    case ($urandom_range(0, 19))
      0, 1: row.req.space_left = 31'($urandom_range(0, need - 1));
      2: row.req.space_left = need;
      3: row.req.space_left = need - 31'd1;
      4: row.req.space_left = LEN_MAX;
      5, 6, 7: row.req.space_left = (r31 < need) ? need : r31;
      default: row.req.space_left = 31'($urandom_range(need, 300));
    endcase
    // Some running lengths sit close enough to the top to saturate.
    case ($urandom_range(0, 7))
      0: row.req.prior_length = LEN_MAX - 31'($urandom_range(0, 25));
      1, 2: row.req.prior_length = 31'($urandom);
      default: row.req.prior_length = 31'($urandom_range(0, 5000));
    endcase
    return row;
  endfunction

  task automatic report_field(input string name, input longint unsigned want,
                              input longint unsigned got);
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    error_count++;
  endtask

  // Every strobe must match the oldest owed character, field by field.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && strobe_o) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character %h, nothing owed", $time, res_o);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (res_o.char_code !== want.char_code)
          report_field("char_code", want.char_code, res_o.char_code);
        if (res_o.last_char !== want.last_char)
          report_field("last_char", want.last_char, res_o.last_char);
        if (res_o.accepted !== want.accepted)
          report_field("accepted", want.accepted, res_o.accepted);
        if (res_o.space_after !== want.space_after)
          report_field("space_after", want.space_after, res_o.space_after);
        if (res_o.length_after !== want.length_after)
          report_field("length_after", want.length_after, res_o.length_after);
      end
    end
  end

  // Hard stop in case the block hangs or drops characters.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned burst_left;
    start  = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table: zero, the ends of every mode, the most negative values,
    // upper-word junk in narrow modes, saturation of the running length and
    // refusals just below each bound.
    add_row(MODE_U32, 64'd0, 31'd11, 31'd0, 1, "0", 31'd10, 31'd1);
    add_row(MODE_U32, 64'hDEAD_BEEF_FFFF_FFFF, 31'd11, 31'd5, 1, "4294967295",
            31'd1, 31'd15);
    add_row(MODE_S32, 64'h0000_0000_8000_0000, 31'd11, 31'd0, 1, "-2147483648",
            31'd0, 31'd11);
    add_row(MODE_S32, 64'h0000_0000_7FFF_FFFF, 31'd100, 31'd7, 1, "2147483647",
            31'd90, 31'd17);
    add_row(MODE_S32, 64'h0000_0000_FFFF_FFFF, 31'd11, 31'd0, 1, "-1", 31'd9, 31'd2);
    add_row(MODE_U64, 64'hFFFF_FFFF_FFFF_FFFF, 31'd21, 31'd0, 1,
            "18446744073709551615", 31'd1, 31'd20);
    add_row(MODE_S64, 64'h8000_0000_0000_0000, 31'd21, 31'd100, 1,
            "-9223372036854775808", 31'd1, 31'd120);
    add_row(MODE_S64, 64'h7FFF_FFFF_FFFF_FFFF, LEN_MAX, 31'd0, 1,
            "9223372036854775807", 31'd2147483628, 31'd19);
    add_row(MODE_S64, 64'hFFFF_FFFF_FFFF_FFFF, 31'd21, LEN_MAX, 1, "-1", 31'd19, LEN_MAX);
    add_row(MODE_U64, 64'd0, 31'd21, 31'd2147483646, 1, "0", 31'd20, LEN_MAX);
    add_row(MODE_U32, 64'd1234567890, 31'd50, 31'd2147483640, 1, "1234567890",
            31'd40, LEN_MAX);
    add_row(MODE_U32, 64'hFFFF_FFFF_0000_0000, 31'd11, 31'd0, 1, "0", 31'd10, 31'd1);
    add_row(MODE_S32, 64'hFFFF_FFFF_0000_0007, 31'd12, 31'd9, 1, "7", 31'd11, 31'd10);
    add_row(MODE_U32, 64'd5, 31'd10, 31'd3, 1, "", 31'd10, 31'd3);
    add_row(MODE_S32, 64'h0000_0000_8000_0000, 31'd0, LEN_MAX, 1, "", 31'd0, LEN_MAX);
    add_row(MODE_U64, 64'd42, 31'd20, 31'd0, 1, "", 31'd20, 31'd0);
    add_row(MODE_S64, 64'h8000_0000_0000_0000, 31'd11, 31'd77, 1, "", 31'd11, 31'd77);
    add_row(MODE_U64, 64'hFFFF_FFFF_FFFF_FFFF, 31'd0, 31'd0, 1, "", 31'd0, 31'd0);
    add_row(MODE_U64, 64'd10000000000000000000, 31'd40, 31'd3, 0, "", 31'd0, 31'd0);
    add_row(MODE_S32, 64'hFFFF_FFFF_FFFF_FFF6, 31'd11, 31'd0, 0, "", 31'd0, 31'd0);
    add_row(MODE_S64, -64'd1000000000000000000, 31'd30, 31'd8, 0, "", 31'd0, 31'd0);
    add_row(MODE_U32, 64'd1000000000, 31'd11, 31'd0, 0, "", 31'd0, 31'd0);

    // Back to back, so the queue fills and busy gets exercised early.
    foreach (directed_rows[i]) send_row(directed_rows[i]);
    wait_for_drain();

    // Random part: bursts of random length split by gaps of random length,
    // one stretch with no gaps at all, and a full drain now and then.
    burst_left = $urandom_range(1, 16);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 119) wait_for_drain();
      send_row(random_row());
      if (n < 200 || n >= 280) begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          idle_cycles(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 60));
        end
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
